@@ rtl/core/m68pd_pkg.sv @@
package m68pd_pkg;

   localparam int unsigned TblLen   = 99;
   localparam int unsigned MatchCnt = 98;   // entries that really compare
   localparam logic [6:0]  CatchAll = 7'd98;

   // row flags
   localparam logic [7:0] FL_EAS = 8'h01;
   localparam logic [7:0] FL_EAD = 8'h02;
   localparam logic [7:0] FL_BR  = 8'h04;
   localparam logic [7:0] FL_DB  = 8'h08;
   localparam logic [7:0] FL_IMB = 8'h10;
   localparam logic [7:0] FL_IMW = 8'h20;
   localparam logic [7:0] FL_IML = 8'h30;
   localparam logic [7:0] FL_IMK = 8'h30;
   localparam logic [7:0] FL_LOB = 8'h40;
   localparam logic [7:0] FL_QK  = 8'h80;

   localparam logic [1:0] SizeLong = 2'd3;

   // effective address mode / register codes
   localparam logic [2:0] ModeDisp    = 3'd5;
   localparam logic [2:0] ModeIndex   = 3'd6;
   localparam logic [2:0] ModeSpecial = 3'd7;
   localparam logic [2:0] RegAbsW     = 3'd0;
   localparam logic [2:0] RegAbsL     = 3'd1;
   localparam logic [2:0] RegPcDisp   = 3'd2;
   localparam logic [2:0] RegPcIndex  = 3'd3;
   localparam logic [2:0] RegImm      = 3'd4;

   typedef logic [6:0] index_type;

   typedef struct packed {
      logic [15:0] mask;
      logic [15:0] pat;
      logic [1:0]  size;
      logic [7:0]  flags;
   } row_type;

   typedef struct packed {
      logic [23:0] instr_addr;
      logic [15:0] opcode_word;
      logic [15:0] ext_word0;
      logic [15:0] ext_word1;
      logic [15:0] ext_word2;
      logic [15:0] ext_word3;
   } req_type;

   typedef struct packed {
      req_type    req;
      index_type  entry_index;
      logic [1:0] operand_size;
      logic [7:0] flags;
   } sel_type;

   typedef struct packed {
      index_type   entry_index;
      logic [3:0]  length_bytes;
      logic [1:0]  operand_size;
      logic        target_valid;
      logic [23:0] target_addr;
      logic        imm_valid;
      logic [31:0] imm_value;
      logic [1:0]  src_ext_words;
      logic [1:0]  dst_ext_words;
   } rsp_type;

   localparam row_type DECODE_ROWS [TblLen] = '{
      '{16'hffc0, 16'h0000, 2'd1, FL_EAS | FL_IMB},
      '{16'hffc0, 16'h0040, 2'd2, FL_EAS | FL_IMW},
      '{16'hffc0, 16'h0080, 2'd3, FL_EAS | FL_IML},
      '{16'hf1c0, 16'h0100, 2'd1, FL_EAS},
      '{16'hf1c0, 16'h0140, 2'd1, FL_EAS},
      '{16'hf1c0, 16'h0180, 2'd1, FL_EAS},
      '{16'hf1c0, 16'h01c0, 2'd1, FL_EAS},
      '{16'hffc0, 16'h0200, 2'd1, FL_EAS | FL_IMB},
      '{16'hffc0, 16'h0240, 2'd2, FL_EAS | FL_IMW},
      '{16'hffc0, 16'h0280, 2'd3, FL_EAS | FL_IML},
      '{16'hffc0, 16'h0400, 2'd1, FL_EAS | FL_IMB},
      '{16'hffc0, 16'h0440, 2'd2, FL_EAS | FL_IMW},
      '{16'hffc0, 16'h0480, 2'd3, FL_EAS | FL_IML},
      '{16'hffc0, 16'h0600, 2'd1, FL_EAS | FL_IMB},
      '{16'hffc0, 16'h0640, 2'd2, FL_EAS | FL_IMW},
      '{16'hffc0, 16'h0680, 2'd3, FL_EAS | FL_IML},
      '{16'hffc0, 16'h0800, 2'd1, FL_EAS | FL_IMB},
      '{16'hffc0, 16'h0840, 2'd1, FL_EAS | FL_IMB},
      '{16'hffc0, 16'h0880, 2'd1, FL_EAS | FL_IMB},
      '{16'hffc0, 16'h08c0, 2'd1, FL_EAS | FL_IMB},
      '{16'hffc0, 16'h0a00, 2'd1, FL_EAS | FL_IMB},
      '{16'hffc0, 16'h0a40, 2'd2, FL_EAS | FL_IMW},
      '{16'hffc0, 16'h0a80, 2'd3, FL_EAS | FL_IML},
      '{16'hffc0, 16'h0c00, 2'd1, FL_EAS | FL_IMB},
      '{16'hffc0, 16'h0c40, 2'd2, FL_EAS | FL_IMW},
      '{16'hffc0, 16'h0c80, 2'd3, FL_EAS | FL_IML},
      '{16'hf000, 16'h1000, 2'd1, FL_EAS | FL_EAD},
      '{16'hf1c0, 16'h2040, 2'd3, FL_EAS | FL_EAD},
      '{16'hf000, 16'h2000, 2'd3, FL_EAS | FL_EAD},
      '{16'hf1c0, 16'h3040, 2'd2, FL_EAS | FL_EAD},
      '{16'hf000, 16'h3000, 2'd2, FL_EAS | FL_EAD},
      '{16'hf1c0, 16'h41c0, 2'd0, FL_EAS},
      '{16'hffc0, 16'h4a00, 2'd1, FL_EAS},
      '{16'hffc0, 16'h4a40, 2'd2, FL_EAS},
      '{16'hffc0, 16'h4a80, 2'd3, FL_EAS},
      '{16'hffc0, 16'h4c80, 2'd2, FL_EAS | FL_IMW},
      '{16'hffc0, 16'h4cc0, 2'd3, FL_EAS | FL_IMW},
      '{16'hfff8, 16'h4e60, 2'd0, 8'h00},
      '{16'hfff8, 16'h4e68, 2'd0, 8'h00},
      '{16'hfff8, 16'h50c8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h51c8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h52c8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h53c8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h54c8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h55c8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h56c8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h57c8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h58c8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h59c8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h5ac8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h5bc8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h5cc8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h5dc8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h5ec8, 2'd0, FL_BR | FL_DB},
      '{16'hfff8, 16'h5fc8, 2'd0, FL_BR | FL_DB},
      '{16'hf1c0, 16'h5000, 2'd1, FL_QK | FL_EAS},
      '{16'hf1c0, 16'h5040, 2'd2, FL_QK | FL_EAS},
      '{16'hf1c0, 16'h5080, 2'd3, FL_QK | FL_EAS},
      '{16'hf1c0, 16'h5100, 2'd1, FL_QK | FL_EAS},
      '{16'hf1c0, 16'h5140, 2'd2, FL_QK | FL_EAS},
      '{16'hf1c0, 16'h5180, 2'd3, FL_QK | FL_EAS},
      '{16'hff00, 16'h6000, 2'd0, FL_BR},
      '{16'hff00, 16'h6100, 2'd0, FL_BR},
      '{16'hff00, 16'h6200, 2'd0, FL_BR},
      '{16'hff00, 16'h6300, 2'd0, FL_BR},
      '{16'hff00, 16'h6400, 2'd0, FL_BR},
      '{16'hff00, 16'h6500, 2'd0, FL_BR},
      '{16'hff00, 16'h6600, 2'd0, FL_BR},
      '{16'hff00, 16'h6700, 2'd0, FL_BR},
      '{16'hff00, 16'h6800, 2'd0, FL_BR},
      '{16'hff00, 16'h6900, 2'd0, FL_BR},
      '{16'hff00, 16'h6a00, 2'd0, FL_BR},
      '{16'hff00, 16'h6b00, 2'd0, FL_BR},
      '{16'hff00, 16'h6c00, 2'd0, FL_BR},
      '{16'hff00, 16'h6d00, 2'd0, FL_BR},
      '{16'hff00, 16'h6e00, 2'd0, FL_BR},
      '{16'hff00, 16'h6f00, 2'd0, FL_BR},
      '{16'hf100, 16'h7000, 2'd0, FL_LOB},
      '{16'hf1c0, 16'hd000, 2'd1, FL_EAS},
      '{16'hf1c0, 16'hd040, 2'd2, FL_EAS},
      '{16'hf1c0, 16'hd080, 2'd3, FL_EAS},
      '{16'hf1c0, 16'hd0c0, 2'd2, FL_EAS},
      '{16'hf1c0, 16'hd100, 2'd1, FL_EAS},
      '{16'hf1c0, 16'hd140, 2'd2, FL_EAS},
      '{16'hf1c0, 16'hd180, 2'd3, FL_EAS},
      '{16'hf1c0, 16'hd1c0, 2'd3, FL_EAS},
      '{16'hf1f8, 16'he008, 2'd1, FL_QK},
      '{16'hf1f8, 16'he048, 2'd2, FL_QK},
      '{16'hf1f8, 16'he088, 2'd3, FL_QK},
      '{16'hf1f8, 16'he028, 2'd1, 8'h00},
      '{16'hf1f8, 16'he068, 2'd2, 8'h00},
      '{16'hf1f8, 16'he0a8, 2'd3, 8'h00},
      '{16'hf1f8, 16'he108, 2'd1, FL_QK},
      '{16'hf1f8, 16'he148, 2'd2, FL_QK},
      '{16'hf1f8, 16'he188, 2'd3, FL_QK},
      '{16'hf1f8, 16'he128, 2'd1, 8'h00},
      '{16'hf1f8, 16'he168, 2'd2, 8'h00},
      '{16'hf1f8, 16'he1a8, 2'd3, 8'h00},
      '{16'h0000, 16'h0000, 2'd0, 8'h00}
   };

   // extension words taken by one effective address
   function automatic logic [1:0] ea_words(logic [2:0] mode, logic [2:0] ea_reg,
                                           logic [1:0] size);
      logic [1:0] words;
      words = 2'd0;
      if (mode == ModeDisp || mode == ModeIndex) begin
         words = 2'd1;
      end else if (mode == ModeSpecial) begin
         case (ea_reg)
            RegAbsW, RegPcDisp, RegPcIndex: words = 2'd1;
            RegAbsL:                        words = 2'd2;
            RegImm:                         words = (size == SizeLong) ? 2'd2 : 2'd1;
            default:                        words = 2'd0;
         endcase
      end
      return words;
   endfunction

endpackage

@@ rtl/core/m68pd_match.sv @@
module m68pd_match (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  up_valid,
   output logic                                  up_stall,
   input  m68pd_pkg::req_type                    up_req,
   output logic                                  dn_valid,
   input  logic                                  dn_stall,
   output m68pd_pkg::req_type                    dn_req,
   output logic [m68pd_pkg::MatchCnt-1:0]        dn_match
);

   logic                              valid_ff;
   m68pd_pkg::req_type                req_ff;
   logic [m68pd_pkg::MatchCnt-1:0]    match_ff;
   logic [m68pd_pkg::MatchCnt-1:0]    match_in;

   always_comb begin
      for (int i = 0; i < int'(m68pd_pkg::MatchCnt); i++) begin
         match_in[i] = (up_req.opcode_word & m68pd_pkg::DECODE_ROWS[i].mask)
                       == m68pd_pkg::DECODE_ROWS[i].pat;
      end
   end

   assign up_stall = valid_ff && dn_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall && up_valid) begin
         req_ff   <= up_req;
         match_ff <= match_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_req   = req_ff;
   assign dn_match = match_ff;

endmodule

@@ rtl/core/m68pd_select.sv @@
module m68pd_select (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             up_valid,
   output logic                             up_stall,
   input  m68pd_pkg::req_type               up_req,
   input  logic [m68pd_pkg::MatchCnt-1:0]   up_match,
   output logic                             dn_valid,
   input  logic                             dn_stall,
   output m68pd_pkg::sel_type               dn_sel
);

   logic                  valid_ff;
   m68pd_pkg::sel_type    sel_ff;
   m68pd_pkg::sel_type    sel_in;
   m68pd_pkg::index_type  index_in;
   m68pd_pkg::row_type    row;

   // lowest matching entry wins; none falls to the catch-all
   always_comb begin
      index_in = m68pd_pkg::CatchAll;
      for (int i = int'(m68pd_pkg::MatchCnt) - 1; i >= 0; i--) begin
         if (up_match[i]) begin
            index_in = 7'(i);
         end
      end
   end

   assign row = m68pd_pkg::DECODE_ROWS[index_in];

   always_comb begin
      sel_in.req          = up_req;
      sel_in.entry_index  = index_in;
      sel_in.operand_size = row.size;
      sel_in.flags        = row.flags;
   end

   assign up_stall = valid_ff && dn_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall && up_valid) begin
         sel_ff <= sel_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_sel   = sel_ff;

endmodule

@@ rtl/core/m68pd_exec.sv @@
module m68pd_exec (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  up_valid,
   output logic                  up_stall,
   input  m68pd_pkg::sel_type    up_sel,
   output logic                  dn_valid,
   input  logic                  dn_stall,
   output m68pd_pkg::rsp_type    dn_rsp
);

   logic                 valid_ff;
   m68pd_pkg::rsp_type   rsp_ff;
   m68pd_pkg::rsp_type   rsp_in;

   logic [15:0] op;
   logic [7:0]  fl;
   logic        is_br;
   logic        br_word;
   logic [23:0] disp;
   logic [31:0] imm;
   logic        imm_hit;
   logic [2:0]  imm_bytes;
   logic [2:0]  quick;
   logic [1:0]  src_words;
   logic [1:0]  dst_words;
   logic [4:0]  len_sum;

   assign op    = up_sel.req.opcode_word;
   assign fl    = up_sel.flags;
   assign is_br = (fl & m68pd_pkg::FL_BR) != 8'h00;

   // DBcc, or a zero low byte, takes the 16-bit displacement word
   assign br_word = is_br && (((fl & m68pd_pkg::FL_DB) != 8'h00) || op[7:0] == 8'h00);
   assign disp    = br_word ? {{8{up_sel.req.ext_word0[15]}}, up_sel.req.ext_word0}
                            : {{16{op[7]}}, op[7:0]};
   assign quick   = op[11:9];

   always_comb begin
      imm       = 32'd0;
      imm_hit   = 1'b0;
      imm_bytes = 3'd0;
      if ((fl & m68pd_pkg::FL_LOB) != 8'h00) begin
         imm     = {24'd0, op[7:0]};
         imm_hit = 1'b1;
      end
      case (fl & m68pd_pkg::FL_IMK)
         m68pd_pkg::FL_IMB: begin
            imm       = {24'd0, up_sel.req.ext_word0[7:0]};
            imm_hit   = 1'b1;
            imm_bytes = 3'd2;
         end
         m68pd_pkg::FL_IMW: begin
            imm       = {16'd0, up_sel.req.ext_word0};
            imm_hit   = 1'b1;
            imm_bytes = 3'd2;
         end
         m68pd_pkg::FL_IML: begin
            imm       = {up_sel.req.ext_word0, up_sel.req.ext_word1};
            imm_hit   = 1'b1;
            imm_bytes = 3'd4;
         end
         default: begin
         end
      endcase
      if ((fl & m68pd_pkg::FL_QK) != 8'h00) begin
         imm     = (quick == 3'd0) ? 32'd8 : {29'd0, quick};
         imm_hit = 1'b1;
      end
   end

   assign src_words = ((fl & m68pd_pkg::FL_EAS) != 8'h00)
                      ? m68pd_pkg::ea_words(op[5:3], op[2:0], up_sel.operand_size) : 2'd0;
   assign dst_words = ((fl & m68pd_pkg::FL_EAD) != 8'h00)
                      ? m68pd_pkg::ea_words(op[8:6], op[11:9], up_sel.operand_size) : 2'd0;

   assign len_sum = 5'd2 + (br_word ? 5'd2 : 5'd0) + {2'd0, imm_bytes}
                    + {2'd0, src_words, 1'b0} + {2'd0, dst_words, 1'b0};

   always_comb begin
      rsp_in.entry_index   = up_sel.entry_index;
      rsp_in.length_bytes  = len_sum[3:0];
      rsp_in.operand_size  = up_sel.operand_size;
      rsp_in.target_valid  = is_br;
      rsp_in.target_addr   = is_br ? (up_sel.req.instr_addr + 24'd2 + disp) : 24'd0;
      rsp_in.imm_valid     = imm_hit;
      rsp_in.imm_value     = imm;
      rsp_in.src_ext_words = src_words;
      rsp_in.dst_ext_words = dst_words;
   end

   assign up_stall = valid_ff && dn_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!up_stall) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!up_stall && up_valid) begin
         rsp_ff <= rsp_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_rsp   = rsp_ff;

endmodule

@@ rtl/core/m68k_instruction_predecoder_top.sv @@
// channel   direction  handshake            payload
// req_      in         req_valid/req_stall  address, opcode word, four extension words
// rsp_      out        rsp_valid/rsp_stall  entry, length, size, target, immediate, ea words
//
// One request per cycle while no stall holds it; requests pass through match, select, exec.
// Each stage is a register with its own valid bit, so bubbles close up under stall.
// rsp_stall backs up stage by stage; req_stall rises only when the match stage is full
// and cannot move on. Reset (synchronous) clears the valid bits only.
module m68k_instruction_predecoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [23:0] req_instr_addr,
   input  logic [15:0] req_opcode_word,
   input  logic [15:0] req_ext_word0,
   input  logic [15:0] req_ext_word1,
   input  logic [15:0] req_ext_word2,
   input  logic [15:0] req_ext_word3,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_entry_index,
   output logic [3:0]  rsp_length_bytes,
   output logic [1:0]  rsp_operand_size,
   output logic        rsp_target_valid,
   output logic [23:0] rsp_target_addr,
   output logic        rsp_imm_valid,
   output logic [31:0] rsp_imm_value,
   output logic [1:0]  rsp_src_ext_words,
   output logic [1:0]  rsp_dst_ext_words
);

   m68pd_pkg::req_type                req;
   m68pd_pkg::req_type                m_req;
   logic [m68pd_pkg::MatchCnt-1:0]    m_match;
   logic                              m_valid;
   logic                              m_stall;
   m68pd_pkg::sel_type                s_sel;
   logic                              s_valid;
   logic                              s_stall;
   m68pd_pkg::rsp_type                rsp;

   always_comb begin
      req.instr_addr  = req_instr_addr;
      req.opcode_word = req_opcode_word;
      req.ext_word0   = req_ext_word0;
      req.ext_word1   = req_ext_word1;
      req.ext_word2   = req_ext_word2;
      req.ext_word3   = req_ext_word3;
   end

   m68pd_match u_match (
      .clock    (clock),
      .reset    (reset),
      .up_valid (req_valid),
      .up_stall (req_stall),
      .up_req   (req),
      .dn_valid (m_valid),
      .dn_stall (m_stall),
      .dn_req   (m_req),
      .dn_match (m_match)
   );

   m68pd_select u_select (
      .clock    (clock),
      .reset    (reset),
      .up_valid (m_valid),
      .up_stall (m_stall),
      .up_req   (m_req),
      .up_match (m_match),
      .dn_valid (s_valid),
      .dn_stall (s_stall),
      .dn_sel   (s_sel)
   );

   m68pd_exec u_exec (
      .clock    (clock),
      .reset    (reset),
      .up_valid (s_valid),
      .up_stall (s_stall),
      .up_sel   (s_sel),
      .dn_valid (rsp_valid),
      .dn_stall (rsp_stall),
      .dn_rsp   (rsp)
   );

   assign rsp_entry_index   = rsp.entry_index;
   assign rsp_length_bytes  = rsp.length_bytes;
   assign rsp_operand_size  = rsp.operand_size;
   assign rsp_target_valid  = rsp.target_valid;
   assign rsp_target_addr   = rsp.target_addr;
   assign rsp_imm_valid     = rsp.imm_valid;
   assign rsp_imm_value     = rsp.imm_value;
   assign rsp_src_ext_words = rsp.src_ext_words;
   assign rsp_dst_ext_words = rsp.dst_ext_words;

`ifndef ASSERT_OFF
   // branch and immediate entries never overlap in the table
   a_br_no_imm: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_target_valid && rsp_imm_valid))
      else $error("branch result carries an immediate");

   a_unknown_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_entry_index == m68pd_pkg::CatchAll
      |-> rsp_length_bytes == 4'd2 && rsp_operand_size == 2'd0 && !rsp_imm_valid)
      else $error("unknown opcode with nonzero extension");

   a_br_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_target_valid |-> rsp_length_bytes == 4'd2 || rsp_length_bytes == 4'd4)
      else $error("branch length out of range");

   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      s_valid && s_stall |=> s_valid)
      else $error("select stage dropped a stalled request");
`endif

endmodule
